// File: src/msw_pkg.sv
// msw_pkg: types and fixed constants of the message statistics window core.
// Depends on nothing; used by message_statistics_window_core.
`timescale 1ns / 1ps

package msw_pkg;

    localparam logic [1:0] OP_RECORD    = 2'd0;
    localparam logic [1:0] OP_MALFORMED = 2'd1;
    localparam logic [1:0] OP_SNAPSHOT  = 2'd2;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] MAX24 = 24'hFF_FFFF;

    // minute mod is taken four bits per step: 8 steps over 32 bits
    localparam logic [2:0] MOD_LAST = 3'd7;
    // 24 quotient bits, one per cycle
    localparam logic [4:0] DIV_LAST = 5'd23;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] count;
    } bucket_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_REC_RD,
        ST_REC_WR,
        ST_SNAP_RD,
        ST_SNAP_WAIT,
        ST_LVL_RD,
        ST_LVL_LOAD
    } state_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == MAX32) ? v : v + 32'd1;
    endfunction

endpackage

// File: src/message_statistics_window_core.sv
// Message statistics window core: counters, length statistics and a per-minute
// bucket ring held in synchronous memories. Depends on msw_pkg.
`timescale 1ns / 1ps

// After reset the core sweeps the bucket memory clear, one entry per cycle,
// with s_ready low. A malformed-count item or an unknown op leaves the core
// idle. A record item runs through the transfer, eight steps of the
// minute-mod-NUM_BUCKETS unit (four bits per step) and a read and a write of
// the bucket memory. A snapshot sweeps the bucket memory one entry per cycle
// while a bit-serial divider forms the 24-bit average, then reads each level
// result through the level-count memory port and loads it once the output
// register is free. The input side is taken again as soon as the last result
// sits in the output register.
module message_statistics_window_core #(
    parameter int NUM_BUCKETS = 60,
    parameter int NUM_LEVELS  = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [2:0]  s_level,
    input  logic [15:0] s_length,
    input  logic [31:0] s_minute,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_total,
    output logic [31:0] m_invalid_count,
    output logic [15:0] m_min_length,
    output logic [15:0] m_max_length,
    output logic [23:0] m_average_length,
    output logic [31:0] m_window_count,
    output logic [2:0]  m_level_index,
    output logic [31:0] m_level_count,
    output logic        m_last
);

    localparam int BIW = $clog2(NUM_BUCKETS);
    localparam int RW  = BIW + 1;
    localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam logic [RW-1:0]  NB_R     = RW'(NUM_BUCKETS);
    localparam logic [BIW-1:0] LAST_BKT = BIW'(NUM_BUCKETS - 1);
    localparam logic [31:0]    WIN_SPAN = 32'(NUM_BUCKETS - 1);
    localparam logic [LVW-1:0] LAST_LVL = LVW'(NUM_LEVELS - 1);
    localparam logic [3:0]     NLVL_W   = 4'(NUM_LEVELS);

    msw_pkg::state_t state_reg, state_next;

    logic [31:0] total_reg;
    logic [31:0] malformed_reg;
    logic [47:0] length_sum_reg;
    logic [15:0] shortest_reg;
    logic [15:0] longest_reg;

    logic [2:0]  item_level_reg;
    logic        item_level_ok_reg;
    logic [15:0] item_length_reg;
    logic [31:0] item_minute_reg;

    logic [2:0]    mod_cnt_reg;
    logic [31:0]   mod_sh_reg;
    logic [RW-1:0] mod_rem_reg, mod_rem_next;

    logic [BIW-1:0] ctr_reg;
    logic           sweep_vld_reg;
    logic           all_pass_reg;
    logic [31:0]    oldest_reg;
    logic [31:0]    win_acc_reg;
    logic [32:0]    win_sum;

    logic        div_busy_reg;
    logic [4:0]  div_cnt_reg;
    logic [31:0] div_rem_reg;
    logic [23:0] div_lo_reg;
    logic [23:0] avg_reg;
    logic [32:0] div_trial;
    logic        div_ge;

    logic [LVW-1:0] lvl_k_reg;

    // bucket memory
    msw_pkg::bucket_t bkt_mem [NUM_BUCKETS];
    msw_pkg::bucket_t bkt_rdata_reg;
    msw_pkg::bucket_t bkt_wdata;
    logic             bkt_rd_en;
    logic [BIW-1:0]   bkt_rd_addr;
    logic             bkt_we;
    logic [BIW-1:0]   bkt_waddr;

    // level-count memory, entries read as zero until first written
    logic [31:0]           lvl_mem [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] lvl_vld_reg;
    logic [31:0]           lvl_rdata_reg;
    logic                  lvl_rd_en;
    logic [LVW-1:0]        lvl_rd_addr;
    logic                  lvl_we;

    logic        m_valid_reg;
    logic [31:0] m_total_reg;
    logic [31:0] m_invalid_count_reg;
    logic [15:0] m_min_length_reg;
    logic [15:0] m_max_length_reg;
    logic [23:0] m_average_length_reg;
    logic [31:0] m_window_count_reg;
    logic [2:0]  m_level_index_reg;
    logic [31:0] m_level_count_reg;
    logic        m_last_reg;

    logic out_free;
    logic load_out;
    logic s_xfer;
    logic [48:0] len_sum_wide;
    logic        rec_first;

    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msw_pkg::ST_CLEAR: begin
                if (ctr_reg == LAST_BKT) state_next = msw_pkg::ST_IDLE;
            end
            msw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == msw_pkg::OP_RECORD) state_next = msw_pkg::ST_MOD;
                    else if (s_op == msw_pkg::OP_SNAPSHOT) state_next = msw_pkg::ST_SNAP_RD;
                end
            end
            msw_pkg::ST_MOD: begin
                if (mod_cnt_reg == msw_pkg::MOD_LAST) state_next = msw_pkg::ST_REC_RD;
            end
            msw_pkg::ST_REC_RD:  state_next = msw_pkg::ST_REC_WR;
            msw_pkg::ST_REC_WR:  state_next = msw_pkg::ST_IDLE;
            msw_pkg::ST_SNAP_RD: begin
                if (ctr_reg == LAST_BKT) state_next = msw_pkg::ST_SNAP_WAIT;
            end
            msw_pkg::ST_SNAP_WAIT: begin
                if (!div_busy_reg) state_next = msw_pkg::ST_LVL_RD;
            end
            msw_pkg::ST_LVL_RD:  state_next = msw_pkg::ST_LVL_LOAD;
            msw_pkg::ST_LVL_LOAD: begin
                if (out_free) begin
                    state_next = (lvl_k_reg == LAST_LVL) ? msw_pkg::ST_IDLE
                                                         : msw_pkg::ST_LVL_RD;
                end
            end
            default: state_next = msw_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = 1'b0;
        bkt_rd_en   = 1'b0;
        bkt_rd_addr = mod_rem_reg[BIW-1:0];
        bkt_we      = 1'b0;
        bkt_waddr   = mod_rem_reg[BIW-1:0];
        bkt_wdata   = '0;
        lvl_rd_en   = 1'b0;
        lvl_rd_addr = lvl_k_reg;
        lvl_we      = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            msw_pkg::ST_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = ctr_reg;
            end
            msw_pkg::ST_IDLE: s_ready = 1'b1;
            msw_pkg::ST_REC_RD: begin
                bkt_rd_en   = 1'b1;
                lvl_rd_en   = 1'b1;
                lvl_rd_addr = item_level_reg[LVW-1:0];
            end
            msw_pkg::ST_REC_WR: begin
                bkt_we = 1'b1;
                lvl_we = item_level_ok_reg;
                if (bkt_rdata_reg.tag != item_minute_reg) begin
                    bkt_wdata.tag   = item_minute_reg;
                    bkt_wdata.count = 32'd1;
                end else begin
                    bkt_wdata.tag   = bkt_rdata_reg.tag;
                    bkt_wdata.count = msw_pkg::sat_inc(bkt_rdata_reg.count);
                end
            end
            msw_pkg::ST_SNAP_RD: begin
                bkt_rd_en   = 1'b1;
                bkt_rd_addr = ctr_reg;
            end
            msw_pkg::ST_LVL_RD:   lvl_rd_en = 1'b1;
            msw_pkg::ST_LVL_LOAD: load_out = out_free;
            default: ;
        endcase
    end

    // minute mod NUM_BUCKETS, four bits per step
    always_comb begin
        mod_rem_next = mod_rem_reg;
        for (int i = 0; i < 4; i++) begin
            mod_rem_next = {mod_rem_next[RW-2:0], mod_sh_reg[31-i]};
            if (mod_rem_next >= NB_R) mod_rem_next = mod_rem_next - NB_R;
        end
    end

    assign div_trial = {div_rem_reg, div_lo_reg[23]};
    assign div_ge    = div_trial >= {1'b0, total_reg};
    assign win_sum   = {1'b0, win_acc_reg} + {1'b0, bkt_rdata_reg.count};
    assign len_sum_wide = {1'b0, length_sum_reg} + 49'(item_length_reg);
    assign rec_first = (total_reg == 32'd0);

    always_ff @(posedge aclk) begin
        if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
        if (bkt_rd_en) bkt_rdata_reg <= bkt_mem[bkt_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[item_level_reg[LVW-1:0]] <= msw_pkg::sat_inc(lvl_rdata_reg);
        end
        if (lvl_rd_en) begin
            lvl_rdata_reg <= lvl_vld_reg[lvl_rd_addr] ? lvl_mem[lvl_rd_addr] : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= msw_pkg::ST_CLEAR;
            ctr_reg        <= '0;
            total_reg      <= '0;
            malformed_reg  <= '0;
            length_sum_reg <= '0;
            shortest_reg   <= '0;
            longest_reg    <= '0;
            lvl_vld_reg    <= '0;
            mod_cnt_reg    <= '0;
            mod_rem_reg    <= '0;
            sweep_vld_reg  <= 1'b0;
            div_busy_reg   <= 1'b0;
            lvl_k_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == msw_pkg::ST_CLEAR || state_reg == msw_pkg::ST_SNAP_RD) begin
                ctr_reg <= ctr_reg + 1'b1;
            end

            if (s_xfer && s_op == msw_pkg::OP_MALFORMED) begin
                malformed_reg <= msw_pkg::sat_inc(malformed_reg);
            end

            if (s_xfer && s_op == msw_pkg::OP_RECORD) begin
                mod_cnt_reg <= '0;
                mod_rem_reg <= '0;
            end else if (state_reg == msw_pkg::ST_MOD) begin
                mod_cnt_reg <= mod_cnt_reg + 3'd1;
                mod_rem_reg <= mod_rem_next;
            end

            if (state_reg == msw_pkg::ST_REC_WR) begin
                total_reg      <= msw_pkg::sat_inc(total_reg);
                length_sum_reg <= len_sum_wide[48] ? msw_pkg::MAX48 : len_sum_wide[47:0];
                if (rec_first || item_length_reg < shortest_reg) begin
                    shortest_reg <= item_length_reg;
                end
                if (item_length_reg > longest_reg) longest_reg <= item_length_reg;
                if (item_level_ok_reg) lvl_vld_reg[item_level_reg[LVW-1:0]] <= 1'b1;
            end

            if (s_xfer && s_op == msw_pkg::OP_SNAPSHOT) begin
                ctr_reg   <= '0;
                lvl_k_reg <= '0;
                div_busy_reg <= (total_reg != 32'd0) &&
                                (length_sum_reg < {total_reg, 16'h0000});
            end else if (div_busy_reg && div_cnt_reg == msw_pkg::DIV_LAST) begin
                div_busy_reg <= 1'b0;
            end

            sweep_vld_reg <= (state_reg == msw_pkg::ST_SNAP_RD);

            if (load_out && lvl_k_reg != LAST_LVL) lvl_k_reg <= lvl_k_reg + 1'b1;

            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_level_reg    <= s_level;
            item_level_ok_reg <= {1'b0, s_level} < NLVL_W;
            item_length_reg   <= s_length;
            item_minute_reg   <= s_minute;
            mod_sh_reg        <= s_minute;
        end else if (state_reg == msw_pkg::ST_MOD) begin
            mod_sh_reg <= {mod_sh_reg[27:0], 4'h0};
        end

        if (s_xfer && s_op == msw_pkg::OP_SNAPSHOT) begin
            all_pass_reg <= s_minute < WIN_SPAN;
            oldest_reg   <= s_minute - WIN_SPAN;
            win_acc_reg  <= '0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= length_sum_reg[47:16];
            div_lo_reg   <= {length_sum_reg[15:0], 8'h00};
            if (total_reg == 32'd0) avg_reg <= '0;
            else if (length_sum_reg >= {total_reg, 16'h0000}) avg_reg <= msw_pkg::MAX24;
            else avg_reg <= '0;
        end else begin
            if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                div_rem_reg <= div_ge ? 32'(div_trial - {1'b0, total_reg}) : div_trial[31:0];
                div_lo_reg  <= {div_lo_reg[22:0], 1'b0};
                avg_reg     <= {avg_reg[22:0], div_ge};
            end
            if (sweep_vld_reg && (all_pass_reg || bkt_rdata_reg.tag >= oldest_reg)) begin
                win_acc_reg <= win_sum[32] ? msw_pkg::MAX32 : win_sum[31:0];
            end
        end

        if (load_out) begin
            m_total_reg          <= total_reg;
            m_invalid_count_reg  <= malformed_reg;
            m_min_length_reg     <= shortest_reg;
            m_max_length_reg     <= longest_reg;
            m_average_length_reg <= avg_reg;
            m_window_count_reg   <= win_acc_reg;
            m_level_index_reg    <= 3'(lvl_k_reg);
            m_level_count_reg    <= lvl_rdata_reg;
            m_last_reg           <= (lvl_k_reg == LAST_LVL);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_total          = m_total_reg;
    assign m_invalid_count  = m_invalid_count_reg;
    assign m_min_length     = m_min_length_reg;
    assign m_max_length     = m_max_length_reg;
    assign m_average_length = m_average_length_reg;
    assign m_window_count   = m_window_count_reg;
    assign m_level_index    = m_level_index_reg;
    assign m_level_count    = m_level_count_reg;
    assign m_last           = m_last_reg;

`ifndef NO_ASSERTIONS
    a_rec_to_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_op == msw_pkg::OP_RECORD) |=> state_reg == msw_pkg::ST_MOD)
        else $error("record transfer did not start the modulo unit");

    a_mod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_rem_reg < NB_R)
        else $error("bucket remainder out of range");

    a_bkt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msw_pkg::ST_REC_WR) |-> (bkt_we && bkt_wdata.count != 32'd0))
        else $error("record wrote an empty bucket");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msw_pkg::ST_LVL_LOAD && m_valid_reg && !m_ready)
        |=> (state_reg == msw_pkg::ST_LVL_LOAD && $stable(lvl_k_reg)))
        else $error("level result advanced while output was stalled");
`endif

endmodule

// File: verif/message_statistics_window_core_tb.sv
// Self-checking testbench for message_statistics_window_core: record, malformed and snapshot
// transfers checked against an in-bench model of the counters and the minute bucket ring.
// Depends on msw_pkg and message_statistics_window_core.
`timescale 1ns / 1ps

module message_statistics_window_core_tb;

    localparam int BUCKETS        = 60;
    localparam int LEVELS         = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] total;
        logic [31:0] malformed;
        logic [15:0] min_length;
        logic [15:0] max_length;
        logic [23:0] average_length;
        logic [31:0] window_count;
        logic [2:0]  level_index;
        logic [31:0] level_count;
        logic        last;
    } stats_report_t;

    class msg_stats_scoreboard;
        logic [31:0] total_cnt;
        logic [31:0] malformed_cnt;
        logic [31:0] per_level[LEVELS];
        logic [47:0] len_sum;
        logic [15:0] len_min;
        logic [15:0] len_max;
        logic [31:0] slot_minute[BUCKETS];
        logic [31:0] slot_count[BUCKETS];
        stats_report_t pending_reports[$];
        int errors;
        int checked;

        function new();
            total_cnt = '0;
            malformed_cnt = '0;
            len_sum = '0;
            len_min = '0;
            len_max = '0;
            errors = 0;
            checked = 0;
            foreach (per_level[i]) per_level[i] = '0;
            foreach (slot_minute[i]) begin
                slot_minute[i] = '0;
                slot_count[i] = '0;
            end
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void apply_item(logic [1:0] op, logic [2:0] level, logic [15:0] len,
                                 logic [31:0] minute);
            int slot;
            logic [48:0] wide_sum;
            logic [63:0] acc;
            logic [55:0] quotient;
            logic [23:0] avg;
            longint oldest;
            stats_report_t r;
            case (op)
                msw_pkg::OP_RECORD: begin
                    if (total_cnt == 32'd0 || len < len_min) len_min = len;
                    if (len > len_max) len_max = len;
                    total_cnt = bump(total_cnt);
                    if (int'(level) < LEVELS) per_level[level] = bump(per_level[level]);
                    wide_sum = {1'b0, len_sum} + 49'(len);
                    len_sum = (wide_sum > 49'(msw_pkg::MAX48)) ? msw_pkg::MAX48
                                                               : wide_sum[47:0];
                    slot = int'(minute % BUCKETS);
                    if (slot_minute[slot] != minute) begin
                        slot_minute[slot] = minute;
                        slot_count[slot] = '0;
                    end
                    slot_count[slot] = bump(slot_count[slot]);
                end
                msw_pkg::OP_MALFORMED: begin
                    malformed_cnt = bump(malformed_cnt);
                end
                msw_pkg::OP_SNAPSHOT: begin
                    oldest = longint'({32'd0, minute}) - longint'(BUCKETS) + 1;
                    acc = '0;
                    for (int i = 0; i < BUCKETS; i++) begin
                        if (longint'({32'd0, slot_minute[i]}) >= oldest) begin
                            acc = acc + 64'(slot_count[i]);
                            if (acc > 64'(msw_pkg::MAX32)) acc = 64'(msw_pkg::MAX32);
                        end
                    end
                    if (total_cnt == 32'd0) begin
                        avg = '0;
                    end else begin
                        quotient = {len_sum, 8'd0} / 56'(total_cnt);
                        avg = (quotient > 56'(msw_pkg::MAX24)) ? msw_pkg::MAX24
                                                               : quotient[23:0];
                    end
                    for (int k = 0; k < LEVELS; k++) begin
                        r.total = total_cnt;
                        r.malformed = malformed_cnt;
                        r.min_length = len_min;
                        r.max_length = len_max;
                        r.average_length = avg;
                        r.window_count = acc[31:0];
                        r.level_index = 3'(k);
                        r.level_count = per_level[k];
                        r.last = (k == LEVELS - 1);
                        pending_reports.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_report(stats_report_t got);
            stats_report_t want;
            if (pending_reports.size() == 0) begin
                $error("result transfer with no snapshot pending");
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare("total", want.total, got.total);
            compare("malformed", want.malformed, got.malformed);
            compare("min_length", 32'(want.min_length), 32'(got.min_length));
            compare("max_length", 32'(want.max_length), 32'(got.max_length));
            compare("average_length", 32'(want.average_length), 32'(got.average_length));
            compare("window_count", want.window_count, got.window_count);
            compare("level_index", 32'(want.level_index), 32'(got.level_index));
            compare("level_count", want.level_count, got.level_count);
            compare("last", 32'(want.last), 32'(got.last));
            checked++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = '0;
    logic [2:0]  s_level = '0;
    logic [15:0] s_length = '0;
    logic [31:0] s_minute = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_total;
    logic [31:0] m_invalid_count;
    logic [15:0] m_min_length;
    logic [15:0] m_max_length;
    logic [23:0] m_average_length;
    logic [31:0] m_window_count;
    logic [2:0]  m_level_index;
    logic [31:0] m_level_count;
    logic        m_last;

    msg_stats_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;
    int idle_cycles = 0;
    int items_sent = 0;
    int snapshots_sent = 0;
    stats_report_t seen;

    message_statistics_window_core #(
        .NUM_BUCKETS(BUCKETS),
        .NUM_LEVELS (LEVELS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_level         (s_level),
        .s_length        (s_length),
        .s_minute        (s_minute),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_total         (m_total),
        .m_invalid_count (m_invalid_count),
        .m_min_length    (m_min_length),
        .m_max_length    (m_max_length),
        .m_average_length(m_average_length),
        .m_window_count  (m_window_count),
        .m_level_index   (m_level_index),
        .m_level_count   (m_level_count),
        .m_last          (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen = {m_total, m_invalid_count, m_min_length, m_max_length, m_average_length,
                    m_window_count, m_level_index, m_level_count, m_last};
            sb.check_report(seen);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [2:0] level,
                             input logic [15:0] len, input logic [31:0] minute);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_level  <= level;
        s_length <= len;
        s_minute <= minute;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.apply_item(op, level, len, minute);
        if (op != OP_UNUSED) items_sent++;
        if (op == msw_pkg::OP_SNAPSHOT) snapshots_sent++;
    endtask

    task automatic run_phase(input int quota);
        int target;
        int burst;
        int pick;
        logic [31:0] base;
        logic [15:0] len;
        target = items_sent + quota;
        while (items_sent < target) begin
            case ($urandom_range(3))
                0: base = 32'($urandom_range(150));
                1: base = 32'hFFFF_FFFF - 32'($urandom_range(150));
                default: base = $urandom();
            endcase
            burst = $urandom_range(2, 14);
            for (int i = 0; i < burst; i++) begin
                case ($urandom_range(7))
                    0: len = 16'h0000;
                    1: len = 16'hFFFF;
                    2: len = 16'($urandom_range(255));
                    default: len = 16'($urandom());
                endcase
                pick = $urandom_range(99);
                if (pick < 80)
                    send_item(msw_pkg::OP_RECORD, 3'($urandom_range(7)), len,
                              base + 32'($urandom_range(80)) - 32'd20);
                else if (pick < 92)
                    send_item(msw_pkg::OP_MALFORMED, 3'($urandom_range(7)), len, $urandom());
                else if (pick < 96)
                    send_item(OP_UNUSED, 3'($urandom_range(7)), len, $urandom());
                else
                    send_item(msw_pkg::OP_SNAPSHOT, 3'($urandom_range(7)), len,
                              base + 32'($urandom_range(80)));
            end
            if ($urandom_range(5) == 0)
                send_item(msw_pkg::OP_SNAPSHOT, 3'($urandom_range(7)), 16'($urandom()),
                          $urandom());
            else
                send_item(msw_pkg::OP_SNAPSHOT, 3'($urandom_range(7)), 16'($urandom()),
                          base + 32'($urandom_range(120)) - 32'd20);
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty snapshot, unused op, level range, minute extremes, bucket re-tag
        send_item(msw_pkg::OP_SNAPSHOT, 3'd0, 16'd0, 32'd0);
        send_item(OP_UNUSED, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(msw_pkg::OP_MALFORMED, 3'd0, 16'd0, 32'd0);
        send_item(msw_pkg::OP_RECORD, 3'd0, 16'd0, 32'd0);
        send_item(msw_pkg::OP_RECORD, 3'd5, 16'hFFFF, 32'd59);
        send_item(msw_pkg::OP_RECORD, 3'd6, 16'd1000, 32'd60);
        send_item(msw_pkg::OP_RECORD, 3'd7, 16'd12345, 32'hFFFF_FFFF);
        send_item(msw_pkg::OP_SNAPSHOT, 3'd0, 16'd0, 32'd0);
        send_item(msw_pkg::OP_SNAPSHOT, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(msw_pkg::OP_RECORD, 3'd1, 16'd1, 32'd60);
        send_item(msw_pkg::OP_RECORD, 3'd2, 16'd2, 32'd120);
        send_item(msw_pkg::OP_RECORD, 3'd3, 16'd300, 32'd61);
        send_item(msw_pkg::OP_RECORD, 3'd4, 16'd7, 32'd180);
        send_item(msw_pkg::OP_SNAPSHOT, 3'd0, 16'd0, 32'd119);
        send_item(msw_pkg::OP_SNAPSHOT, 3'd0, 16'd0, 32'd179);
        send_item(msw_pkg::OP_MALFORMED, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(msw_pkg::OP_SNAPSHOT, 3'd0, 16'd0, 32'd180);

        send_idle_pct = 34;
        recv_idle_pct = 55;
        run_phase(130);

        send_idle_pct = 55;
        recv_idle_pct = 34;
        run_phase(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long result hold-off while snapshots keep coming
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_item(msw_pkg::OP_RECORD, 3'($urandom_range(7)), 16'($urandom()),
                      32'd5000 + 32'(i));
            send_item(msw_pkg::OP_SNAPSHOT, 3'd0, 16'd0, 32'd5000 + 32'(i));
        end
        run_phase(120);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.pending_reports.size() != 0) begin
            $error("%0d level reports never arrived", sb.pending_reports.size());
            sb.errors++;
        end
        $display("summary: %0d items (%0d snapshots), %0d level reports checked, %0d mismatches",
                 items_sent, snapshots_sent, sb.checked, sb.errors);
        $display("summary: three idle mixes, a %0d-cycle result hold-off, minute wrap at both ends",
                 HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
